// ===== rtl/sparse_block_image_decoder_top_assert.svh =====
// assertion macros for the sparse block image decoder checker
// expects clk and arst_n in the scope where a macro is used
`ifndef SPARSE_BLOCK_IMAGE_DECODER_TOP_ASSERT_SVH
`define SPARSE_BLOCK_IMAGE_DECODER_TOP_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define SBID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define SBID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sbid_pkg.sv =====
// shared types, codes and header constants for the sparse block image decoder
// no dependencies
`default_nettype none

package sbid_pkg;

	typedef logic [2:0] phase_t;
	typedef logic [1:0] kind_t;
	typedef logic [1:0] err_t;

	localparam int BLOCK_BYTES_DEF = 512;

	localparam phase_t PH_HEADER = 3'd0;
	localparam phase_t PH_DESC   = 3'd1;
	localparam phase_t PH_RAW    = 3'd2;
	localparam phase_t PH_RUN    = 3'd3;
	localparam phase_t PH_STOP   = 3'd4;

	localparam kind_t K_RAW  = 2'd0;
	localparam kind_t K_ZERO = 2'd1;
	localparam kind_t K_DONE = 2'd2;
	localparam kind_t K_ERR  = 2'd3;

	localparam err_t E_MAGIC   = 2'd0;
	localparam err_t E_VERSION = 2'd1;
	localparam err_t E_DESC    = 2'd2;
	localparam err_t E_TRUNC   = 2'd3;

	localparam logic [7:0] DESC_RAW   = 8'h00;
	localparam logic [7:0] DESC_ZERO  = 8'h01;
	localparam logic [2:0] HDR_LAST   = 3'd7;
	localparam logic [2:0] RUN_IDX_MAX = 3'd5;

	// expected magic byte at each header position
	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] m;
		case (idx)
			3'd0:    m = 8'h56;
			3'd1:    m = 8'h4D;
			3'd2:    m = 8'h46;
			3'd3:    m = 8'h53;
			3'd4:    m = 8'h49;
			3'd5:    m = 8'h4D;
			3'd6:    m = 8'h47;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sparse_block_image_decoder_top.sv =====
// sparse block image decoder: header check, raw block pass-through, zero-run varints
// depends on sbid_pkg
`default_nettype none
// usage
//   input channel: in_valid / in_stall carrying op and data_byte; op 0 is one
//   image byte, op 1 marks the end of input. an item is taken at an edge with
//   in_valid high and in_stall low
//   output channel: out_valid / out_stall carrying kind, out_byte, byte_offset,
//   block_done, zero_blocks and error_code. at most one result per input item
//   config: cfg_valid / cfg_ready write max_format_version from cfg_data; the
//   port is always ready, write it only while the decoder is idle
// timing
//   an item taken enters the input register; any result then enters the output
//   register, raising out_valid, once that is free or draining. the state update
//   between them is combinational: one item per cycle while out_stall is low
// reset
//   arst_n low clears both registers' valid bits, returns to the header phase
//   and sets max_format_version to 0
// backpressure
//   while out_stall holds a waiting result, the input register can still
//   fill; in_stall rises only when both registers are occupied
// after a clean end or an error every later item is taken and dropped

module sparse_block_image_decoder_top #(
	parameter int BLOCK_BYTES = sbid_pkg::BLOCK_BYTES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// input item channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         op,
	input  wire  [7:0]  data_byte,
	// result item channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [8:0]  byte_offset,
	output logic        block_done,
	output logic [32:0] zero_blocks,
	output logic [1:0]  error_code,
	// configuration write
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_data
);

	// raw offset counter is just wide enough for BLOCK_BYTES-1
	localparam int RAW_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
	localparam logic [RAW_W-1:0] RAW_LAST = RAW_W'(BLOCK_BYTES - 1);

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// result register
	logic                valid_s2;
	sbid_pkg::kind_t     kind_s2;
	logic [7:0]          byte_s2;
	logic [8:0]          offset_s2;
	logic                done_s2;
	logic [32:0]         blocks_s2;
	sbid_pkg::err_t      err_s2;

	// decoder state
	logic [7:0]          max_ver_q;
	sbid_pkg::phase_t    phase_q, phase_d;
	logic [2:0]          hdr_cnt_q, hdr_cnt_d;
	logic                mism_q, mism_d;
	logic [RAW_W-1:0]    raw_cnt_q, raw_cnt_d;
	logic [31:0]         run_val_q, run_val_d;
	logic [2:0]          run_idx_q, run_idx_d;

	// result of the item in the input register
	logic                res_valid;
	sbid_pkg::kind_t     res_kind;
	logic [7:0]          res_byte;
	logic [8:0]          res_offset;
	logic                res_done;
	logic [32:0]         res_blocks;
	sbid_pkg::err_t      res_err;

	logic                adv;
	logic [31:0]         run_add;
	logic [31:0]         run_acc;
	logic [RAW_W+8:0]    offset_wide;

	// the input register moves on whenever the result register is free or draining
	assign adv       = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	assign offset_wide = {9'b0, raw_cnt_q};

	// varint payload bits placed at the current 7-bit group, dropped past bit 31
	always_comb begin
		case (run_idx_q)
			3'd0:    run_add = {25'b0, byte_s1[6:0]};
			3'd1:    run_add = {18'b0, byte_s1[6:0], 7'b0};
			3'd2:    run_add = {11'b0, byte_s1[6:0], 14'b0};
			3'd3:    run_add = {4'b0, byte_s1[6:0], 21'b0};
			3'd4:    run_add = {byte_s1[3:0], 28'b0};
			default: run_add = 32'b0;
		endcase
	end

	assign run_acc = run_val_q | run_add;

	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		mism_d     = mism_q;
		raw_cnt_d  = raw_cnt_q;
		run_val_d  = run_val_q;
		run_idx_d  = run_idx_q;
		res_valid  = 1'b0;
		res_kind   = sbid_pkg::K_RAW;
		res_byte   = 8'b0;
		res_offset = 9'b0;
		res_done   = 1'b0;
		res_blocks = 33'b0;
		res_err    = sbid_pkg::E_MAGIC;

		if (phase_q == sbid_pkg::PH_STOP) begin
			// stopped: drop everything
		end else if (op_s1) begin
			res_valid = 1'b1;
			phase_d   = sbid_pkg::PH_STOP;
			if (phase_q == sbid_pkg::PH_DESC) begin
				res_kind = sbid_pkg::K_DONE;
			end else begin
				res_kind = sbid_pkg::K_ERR;
				res_err  = sbid_pkg::E_TRUNC;
			end
		end else begin
			unique case (phase_q)
				sbid_pkg::PH_HEADER: begin
					if (hdr_cnt_q != sbid_pkg::HDR_LAST) begin
						if (byte_s1 != sbid_pkg::magic_byte(hdr_cnt_q))
							mism_d = 1'b1;
						hdr_cnt_d = hdr_cnt_q + 3'd1;
					end else if (mism_q) begin
						res_valid = 1'b1;
						res_kind  = sbid_pkg::K_ERR;
						res_err   = sbid_pkg::E_MAGIC;
						phase_d   = sbid_pkg::PH_STOP;
					end else if (byte_s1 > max_ver_q) begin
						res_valid = 1'b1;
						res_kind  = sbid_pkg::K_ERR;
						res_err   = sbid_pkg::E_VERSION;
						phase_d   = sbid_pkg::PH_STOP;
					end else begin
						hdr_cnt_d = 3'd0;
						phase_d   = sbid_pkg::PH_DESC;
					end
				end
				sbid_pkg::PH_DESC: begin
					if (byte_s1 == sbid_pkg::DESC_RAW) begin
						raw_cnt_d = '0;
						phase_d   = sbid_pkg::PH_RAW;
					end else if (byte_s1 == sbid_pkg::DESC_ZERO) begin
						run_val_d = 32'b0;
						run_idx_d = 3'd0;
						phase_d   = sbid_pkg::PH_RUN;
					end else begin
						res_valid = 1'b1;
						res_kind  = sbid_pkg::K_ERR;
						res_err   = sbid_pkg::E_DESC;
						phase_d   = sbid_pkg::PH_STOP;
					end
				end
				sbid_pkg::PH_RAW: begin
					res_valid  = 1'b1;
					res_kind   = sbid_pkg::K_RAW;
					res_byte   = byte_s1;
					res_offset = offset_wide[8:0];
					if (raw_cnt_q == RAW_LAST) begin
						res_done  = 1'b1;
						raw_cnt_d = '0;
						phase_d   = sbid_pkg::PH_DESC;
					end else begin
						raw_cnt_d = raw_cnt_q + RAW_W'(1);
					end
				end
				sbid_pkg::PH_RUN: begin
					if (byte_s1[7]) begin
						run_val_d = run_acc;
						if (run_idx_q < sbid_pkg::RUN_IDX_MAX)
							run_idx_d = run_idx_q + 3'd1;
					end else begin
						// last varint byte: report N+1 blocks
						res_valid  = 1'b1;
						res_kind   = sbid_pkg::K_ZERO;
						res_blocks = {1'b0, run_acc} + 33'd1;
						run_val_d  = 32'b0;
						run_idx_d  = 3'd0;
						phase_d    = sbid_pkg::PH_DESC;
					end
				end
				default: begin
					phase_d = sbid_pkg::PH_STOP;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			max_ver_q <= 8'b0;
			phase_q   <= sbid_pkg::PH_HEADER;
			hdr_cnt_q <= 3'd0;
			mism_q    <= 1'b0;
			raw_cnt_q <= '0;
			run_val_q <= 32'b0;
			run_idx_q <= 3'd0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_ver_q <= cfg_data;
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv) begin
				valid_s2  <= res_valid;
				phase_q   <= phase_d;
				hdr_cnt_q <= hdr_cnt_d;
				mism_q    <= mism_d;
				raw_cnt_q <= raw_cnt_d;
				run_val_q <= run_val_d;
				run_idx_q <= run_idx_d;
			end else if (valid_s2 && !out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			byte_s1 <= data_byte;
		end
		if (adv && res_valid) begin
			kind_s2   <= res_kind;
			byte_s2   <= res_byte;
			offset_s2 <= res_offset;
			done_s2   <= res_done;
			blocks_s2 <= res_blocks;
			err_s2    <= res_err;
		end
	end

	assign out_valid   = valid_s2;
	assign kind        = kind_s2;
	assign out_byte    = byte_s2;
	assign byte_offset = offset_s2;
	assign block_done  = done_s2;
	assign zero_blocks = blocks_s2;
	assign error_code  = err_s2;

endmodule

`default_nettype wire

// ===== rtl/sbid_checker.sv =====
// port-level checks for the sparse block image decoder, bound to its top level
// depends on sbid_pkg and sparse_block_image_decoder_top_assert.svh
`default_nettype none
`include "sparse_block_image_decoder_top_assert.svh"

module sbid_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire [1:0]  kind,
	input wire [32:0] zero_blocks,
	input wire [1:0]  error_code
);

	// a held result stays offered
	`SBID_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// a held result keeps its kind and code
	`SBID_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(kind) && $stable(error_code), "result changed while stalled")

	// a zero run always covers at least one block
	`SBID_ASSERT_NOW(a_run_nonzero, out_valid && kind == sbid_pkg::K_ZERO, zero_blocks != 33'd0, "empty zero run")

	// nothing follows a clean end or an error
	`SBID_ASSERT_NEXT(a_stop_quiet, out_valid && !out_stall && (kind == sbid_pkg::K_DONE || kind == sbid_pkg::K_ERR), !out_valid, "result after end of image")

endmodule

bind sparse_block_image_decoder_top sbid_checker u_sbid_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kind        (kind),
	.zero_blocks (zero_blocks),
	.error_code  (error_code)
);

`default_nettype wire

// ===== tb/tb_sparse_block_image_decoder_top.sv =====
// self-checking testbench for sparse_block_image_decoder_top: one image stream is driven through
// the decoder and its results are checked against a cycle-free decoder model held in this file
// depends on sbid_pkg and the decoder rtl
`default_nettype none

module tb_sparse_block_image_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_LEN = sbid_pkg::BLOCK_BYTES_DEF;
	// seven header magic bytes, first byte in the top lane
	localparam logic [55:0] MAGIC = {8'h56, 8'h4D, 8'h46, 8'h53, 8'h49, 8'h4D, 8'h47};
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS   = 115;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} image_item_t;

	typedef struct packed {
		sbid_pkg::kind_t kind;
		logic [7:0]      out_byte;
		logic [8:0]      byte_offset;
		logic            block_done;
		logic [32:0]     zero_blocks;
		sbid_pkg::err_t  error_code;
	} decoded_t;

	// how the stream is brought to its end
	typedef enum int {TERM_CLEAN, TERM_IN_RAW, TERM_IN_RUN, TERM_BAD_DESC} stream_end_t;

	// clock, reset and block ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [8:0]  byte_offset;
	logic        block_done;
	logic [32:0] zero_blocks;
	logic [1:0]  error_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;

	// image items waiting to be offered, decoded results waiting to arrive
	image_item_t image_q[$];
	decoded_t    result_q[$];

	// idling controls, set per phase
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic long_hold = 1'b0;
	int fails = 0;

	// decoder model state, reset once with the block
	sbid_pkg::phase_t dec_phase = sbid_pkg::PH_HEADER;
	logic [8:0]  dec_pos = '0;
	logic        dec_magic_bad = 1'b0;
	logic [31:0] dec_run = '0;
	logic [5:0]  dec_shift = '0;
	logic [7:0]  dec_max_ver = 8'h00;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sparse_block_image_decoder_top #(.BLOCK_BYTES(BLOCK_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.byte_offset(byte_offset),
		.block_done(block_done),
		.zero_blocks(zero_blocks),
		.error_code(error_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// decodes one accepted item, returns 1 when it yields a result
	function automatic bit decode_image_item(input image_item_t it, output decoded_t r);
		logic [31:0] part;
		bit last;
		r = '0;
		// a stopped decoder swallows everything
		if (dec_phase == sbid_pkg::PH_STOP)
			return 1'b0;
		// end marker: clean only at a descriptor boundary
		if (it.op == OP_END) begin
			if (dec_phase == sbid_pkg::PH_DESC) begin
				r.kind = sbid_pkg::K_DONE;
			end else begin
				r.kind = sbid_pkg::K_ERR;
				r.error_code = sbid_pkg::E_TRUNC;
			end
			dec_phase = sbid_pkg::PH_STOP;
			return 1'b1;
		end
		case (dec_phase)
			sbid_pkg::PH_HEADER: begin
				if (int'(dec_pos) < int'(sbid_pkg::HDR_LAST)) begin
					if (it.data != MAGIC[55 - 8 * int'(dec_pos) -: 8])
						dec_magic_bad = 1'b1;
					dec_pos = dec_pos + 9'd1;
					return 1'b0;
				end
				// magic is judged before the version byte
				if (dec_magic_bad || it.data > dec_max_ver) begin
					r.kind = sbid_pkg::K_ERR;
					r.error_code = dec_magic_bad ? sbid_pkg::E_MAGIC : sbid_pkg::E_VERSION;
					dec_phase = sbid_pkg::PH_STOP;
					return 1'b1;
				end
				dec_pos = '0;
				dec_phase = sbid_pkg::PH_DESC;
				return 1'b0;
			end
			sbid_pkg::PH_DESC: begin
				if (it.data == sbid_pkg::DESC_RAW) begin
					dec_pos = '0;
					dec_phase = sbid_pkg::PH_RAW;
					return 1'b0;
				end
				if (it.data == sbid_pkg::DESC_ZERO) begin
					dec_run = '0;
					dec_shift = '0;
					dec_phase = sbid_pkg::PH_RUN;
					return 1'b0;
				end
				r.kind = sbid_pkg::K_ERR;
				r.error_code = sbid_pkg::E_DESC;
				dec_phase = sbid_pkg::PH_STOP;
				return 1'b1;
			end
			sbid_pkg::PH_RAW: begin
				last = (int'(dec_pos) + 1 >= BLOCK_LEN);
				r.kind = sbid_pkg::K_RAW;
				r.out_byte = it.data;
				r.byte_offset = dec_pos;
				r.block_done = last;
				if (last) begin
					dec_pos = '0;
					dec_phase = sbid_pkg::PH_DESC;
				end else begin
					dec_pos = dec_pos + 9'd1;
				end
				return 1'b1;
			end
			sbid_pkg::PH_RUN: begin
				// varint bits landing at bit 32 or above are dropped
				if (dec_shift < 6'd32) begin
					part = 32'(it.data[6:0]) << dec_shift;
					dec_run = dec_run | part;
					dec_shift = dec_shift + 6'd7;
				end
				if (it.data[7])
					return 1'b0;
				r.kind = sbid_pkg::K_ZERO;
				r.zero_blocks = {1'b0, dec_run} + 33'd1;
				dec_run = '0;
				dec_shift = '0;
				dec_phase = sbid_pkg::PH_DESC;
				return 1'b1;
			end
			default: begin
				dec_phase = sbid_pkg::PH_STOP;
				return 1'b0;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		image_q.push_back({OP_BYTE, b});
	endfunction

	// raw descriptor followed by nbytes of random payload
	function automatic void queue_raw_block(input int nbytes);
		int i;
		push_byte(sbid_pkg::DESC_RAW);
		for (i = 0; i < nbytes; i++)
			push_byte(8'($urandom()));
	endfunction

	// zero-run descriptor with a random varint, mostly short; returns items queued
	function automatic int queue_zero_run();
		int len;
		int r;
		int i;
		r = $urandom_range(99);
		if (r < 45)
			len = 1;
		else if (r < 70)
			len = 2;
		else if (r < 90)
			len = $urandom_range(5, 3);
		else
			len = $urandom_range(9, 6);
		push_byte(sbid_pkg::DESC_ZERO);
		for (i = 0; i < len; i++)
			push_byte({i != len - 1, 7'($urandom())});
		return len + 1;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endfunction

	// config write, only ever called while the decoder is idle
	task automatic write_max_version(input logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// all items taken, all results in, then a settle wait for items with no result
	task automatic wait_decoder_idle();
		int k;
		while (image_q.size() != 0 || in_valid)
			@(posedge clk);
		k = 0;
		while (result_q.size() != 0 && k < DRAIN_LIMIT) begin
			@(posedge clk);
			k++;
		end
		if (result_q.size() != 0) begin
			$error("%0d expected results never arrived", result_q.size());
			fails++;
			result_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// input driver: predicts on every accepted item, then offers the next one
	// or idles; a stalled item is held as is
	always @(posedge clk) begin
		decoded_t res;
		image_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (decode_image_item({op, data_byte}, res))
					result_q.push_back(res);
			end
			if (!in_valid || !in_stall) begin
				if (image_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = image_q.pop_front();
					in_valid <= 1'b1;
					op <= nxt.op;
					data_byte <= nxt.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus the long hold-off
	always @(posedge clk) begin
		out_stall <= long_hold || ($urandom_range(99) < stall_pct);
	end

	// result monitor: oldest expectation against every accepted result
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$error("unexpected result: kind %0d", kind);
				fails++;
			end else begin
				want = result_q.pop_front();
				check_field("kind", want.kind, kind);
				check_field("out_byte", want.out_byte, out_byte);
				check_field("byte_offset", want.byte_offset, byte_offset);
				check_field("block_done", want.block_done, block_done);
				check_field("zero_blocks", want.zero_blocks, zero_blocks);
				check_field("error_code", want.error_code, error_code);
			end
		end
	end

	// model copy of the version limit follows every accepted config write
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			dec_max_ver <= cfg_data;
	end

	// long receiver hold-off, counted here once requested
	initial begin
		wait (hold_req);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [7:0] ver_limit;
		stream_end_t ending;
		int i;
		int n;

		// reset held low from time zero, released at an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// both extremes of the version limit, then the one the header uses
		write_max_version(8'hFF);
		write_max_version(8'h00);
		ver_limit = 8'($urandom_range(255));
		write_max_version(ver_limit);

		// header: magic then a version at or under the limit, often right on it
		for (i = 0; i < 7; i++)
			push_byte(MAGIC[55 - 8 * i -: 8]);
		push_byte($urandom_range(1) ? ver_limit : 8'($urandom_range(int'(ver_limit))));

		// zero runs at the varint extremes
		push_byte(sbid_pkg::DESC_ZERO);
		push_byte(8'h00);
		push_byte(sbid_pkg::DESC_ZERO);
		push_byte(8'h7F);
		// all 32 bits set, run of 2^32 blocks
		push_byte(sbid_pkg::DESC_ZERO);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'h0F);
		// long varint: top of the fifth byte and the later bytes drop out
		push_byte(sbid_pkg::DESC_ZERO);
		push_byte(8'h80);
		push_byte(8'h81);
		push_byte(8'h80);
		push_byte(8'h80);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'h01);
		wait_decoder_idle();
		write_max_version(8'h00);

		// backpressure: a long receiver hold-off while a whole raw block is queued
		hold_req = 1'b1;
		queue_raw_block(BLOCK_LEN);
		for (i = 0; i < 10; i++)
			void'(queue_zero_run());
		wait_decoder_idle();
		write_max_version(8'hFF);

		// random zero runs under each idling mix
		for (i = 0; i < 4; i++) begin
			case (i)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 82;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 82;
				end
				default: begin
					send_idle_pct = 27;
					stall_pct = 27;
				end
			endcase
			n = 0;
			while (n < PHASE_ITEMS)
				n += queue_zero_run();
			wait_decoder_idle();
			write_max_version(8'($urandom_range(255)));
		end

		// the stream ends one way or another, then the decoder ignores the rest
		ending = stream_end_t'($urandom_range(3));
		case (ending)
			TERM_IN_RAW: queue_raw_block($urandom_range(8));
			TERM_IN_RUN: begin
				push_byte(sbid_pkg::DESC_ZERO);
				repeat ($urandom_range(4)) push_byte(8'h80 | 8'($urandom()));
			end
			TERM_BAD_DESC: push_byte(8'($urandom_range(255, 2)));
			default: ;
		endcase
		if (ending != TERM_BAD_DESC)
			image_q.push_back({OP_END, 8'($urandom())});
		repeat (8) image_q.push_back(image_item_t'(9'($urandom())));
		wait_decoder_idle();

		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/sbid_pkg.sv
rtl/sparse_block_image_decoder_top.sv
rtl/sbid_checker.sv
tb/tb_sparse_block_image_decoder_top.sv
